### hw/rtl/bof_pkg.sv
// Shared types and codes for the broadcast offset generator.
// No dependencies; used by bof_cell and broadcast_offset_generator_top.
package bof_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MAP    = 2'd2,
    OP_NONE   = 2'd3
  } bof_op_e;

  typedef enum logic [2:0] {
    ST_OK                = 3'd0,
    ST_NOT_BROADCASTABLE = 3'd1,
    ST_SIZE_OVERFLOW     = 3'd2,
    ST_INDEX_TOO_LARGE   = 3'd3,
    ST_ZERO_EXTENT       = 3'd4
  } bof_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ALIGN,
    S_SZ_CHK,
    S_SZ_MUL,
    S_SZ_NEXT,
    S_SZ_END,
    S_DV_CHK,
    S_DV,
    S_MUL,
    S_DONE
  } bof_state_e;

  localparam logic REG_A_RANK = 1'b0;
  localparam logic REG_B_RANK = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  dim_position;
    logic [31:0] extent;
    logic [31:0] linear_index;
  } bof_in_t;

  typedef struct packed {
    logic [31:0] a_offset;
    logic [31:0] b_offset;
    logic [31:0] output_size;
    logic [2:0]  status;
  } bof_out_t;

  // Control broadcast to every cell of the extent chain.
  typedef struct packed {
    logic        load_a;
    logic        load_b;
    logic [2:0]  load_pos;
    logic [31:0] load_ext;
    logic        copy;
    logic        shift_a;
    logic        shift_b;
  } bof_cell_ctl_t;

endpackage

### hw/rtl/bof_cell.sv
// One cell of the extent chain: stored extents of one dimension and a working pair.
// Depends on bof_pkg.
module bof_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bof_pkg::bof_cell_ctl_t ctl_i,
  input  logic [31:0]            left_a_i,
  input  logic [31:0]            left_b_i,
  output logic [31:0]            work_a_o,
  output logic [31:0]            work_b_o
);

  logic [31:0] ext_a_q, ext_b_q, work_a_q, work_b_q;
  logic        hit;

  assign hit = (int'(ctl_i.load_pos) == int'(IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_a_q <= 32'd1;
      ext_b_q <= 32'd1;
    end else begin
      if (ctl_i.load_a && hit) begin
        ext_a_q <= ctl_i.load_ext;
      end
      if (ctl_i.load_b && hit) begin
        ext_b_q <= ctl_i.load_ext;
      end
    end
  end

  // The working pair is copied from storage at the start of a map and then
  // moves along the chain.
  always_ff @(posedge clk_i) begin
    if (ctl_i.copy) begin
      work_a_q <= ext_a_q;
      work_b_q <= ext_b_q;
    end else begin
      if (ctl_i.shift_a) begin
        work_a_q <= left_a_i;
      end
      if (ctl_i.shift_b) begin
        work_b_q <= left_b_i;
      end
    end
  end

  assign work_a_o = work_a_q;
  assign work_b_o = work_b_q;

endmodule

### hw/rtl/broadcast_offset_generator_top.sv
// Top level of the broadcast offset generator: control sequencer, arithmetic and APB registers.
// Depends on bof_pkg and bof_cell.

// The block holds the extents of two operands in a chain of MAX_DIMS cells and
// maps a row-major output index to one element offset per operand under
// right-aligned broadcasting. One item is worked on at a time. A load, or an
// unused opcode, goes straight to the done state, which moves the result into
// the output register once that register is free and then returns to idle,
// where the next input is taken. A map walks the chain: alignment shifts both
// operands onto their last dimension, then each dimension passes through a
// bit-serial multiplier for the output size, and, when the index is in range,
// each dimension takes a set-up step, a bit-serial restoring divider and four
// steps of one shared 32 by 32 multiplier; the bit-serial divider and
// multiplier set how long a map takes. The next input is taken while a finished
// result still waits in the output register. Registers a_rank (byte address 0)
// and b_rank (byte address 4) are to be written over APB only while the block
// is idle; the user must keep to this, as the block itself does not enforce it.
module broadcast_offset_generator_top #(
  parameter int unsigned MAX_DIMS   = 8,
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bof_pkg::bof_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bof_pkg::bof_out_t out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned KW = $clog2(MAX_DIMS + 1);
  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned CW = (IB > 32) ? IB : 32;
  localparam logic [IB-1:0] LIMIT = '1;

  // Configuration registers.
  logic [3:0] a_rank_q, b_rank_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rank_q <= 4'd1;
      b_rank_q <= 4'd1;
    end else if (cfg_wr) begin
      if (paddr[2] == bof_pkg::REG_A_RANK) begin
        a_rank_q <= pwdata[3:0];
      end else begin
        b_rank_q <= pwdata[3:0];
      end
    end
  end

  assign prdata = (paddr[2] == bof_pkg::REG_B_RANK) ? {28'd0, b_rank_q} : {28'd0, a_rank_q};

  // A rank of zero counts as one and a rank beyond the chain saturates.
  function automatic logic [KW-1:0] eff_rank(input logic [3:0] r);
    logic [KW-1:0] e;
    if (r == 4'd0) begin
      e = KW'(1);
    end else if (int'(r) > int'(MAX_DIMS)) begin
      e = KW'(MAX_DIMS);
    end else begin
      e = KW'(r);
    end
    return e;
  endfunction

  logic [KW-1:0] sh_a, sh_b;
  assign sh_a = KW'(MAX_DIMS) - eff_rank(a_rank_q);
  assign sh_b = KW'(MAX_DIMS) - eff_rank(b_rank_q);

  // Extent chain. The tail cell holds the dimension being worked on; a rotation
  // feeds the tail back into the head, during alignment the head takes ones.
  bof_pkg::bof_cell_ctl_t ctl;
  logic [31:0] work_a [MAX_DIMS];
  logic [31:0] work_b [MAX_DIMS];
  logic [31:0] head_a, head_b, ta, tb;
  logic        head_one;

  assign ta     = work_a[MAX_DIMS-1];
  assign tb     = work_b[MAX_DIMS-1];
  assign head_a = head_one ? 32'd1 : ta;
  assign head_b = head_one ? 32'd1 : tb;

  for (genvar g = 0; g < MAX_DIMS; g++) begin : g_cell
    bof_cell #(.IDX(g)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .left_a_i ((g == 0) ? head_a : work_a[(g == 0) ? 0 : g-1]),
      .left_b_i ((g == 0) ? head_b : work_b[(g == 0) ? 0 : g-1]),
      .work_a_o (work_a[g]),
      .work_b_o (work_b[g])
    );
  end

  // Sequencer registers.
  bof_pkg::bof_state_e state_q, state_d;
  logic [KW-1:0]       k_q, k_d;
  logic [4:0]          bit_q, bit_d;
  logic [1:0]          sub_q, sub_d;
  logic [IB-1:0]       size_q, size_d;
  logic [IB+1:0]       acc_q, acc_d;
  logic [31:0]         os_q, os_d;
  logic                incomp_q, incomp_d, ovf_q, ovf_d;
  logic [31:0]         lin_q, lin_d, rem_q, rem_d;
  logic [31:0]         sa_q, sa_d, sb_q, sb_d, offa_q, offa_d, offb_q, offb_d;
  bof_pkg::bof_in_t    item_q, item_d;
  bof_pkg::bof_out_t   res_q, res_d, out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // Datapath helpers.
  logic [31:0]   os_max;
  logic [IB+1:0] acc_n;
  logic [32:0]   div_r;
  logic          div_ge;
  logic [31:0]   mul_x, mul_y;
  logic [63:0]   mul_p;
  logic [CW-1:0] size_cw, lim_cw;

  assign os_max  = (ta > tb) ? ta : tb;
  assign acc_n   = {acc_q[IB:0], 1'b0} + (os_q[bit_q] ? (IB+2)'(size_q) : '0);
  assign div_r   = {rem_q, lin_q[31]};
  assign div_ge  = div_r >= {1'b0, os_q};
  assign mul_p   = mul_x * mul_y;
  assign size_cw = CW'(size_q);
  assign lim_cw  = CW'(LIMIT);

  always_comb begin
    case (sub_q)
      2'd0:    begin mul_x = rem_q; mul_y = sa_q; end
      2'd1:    begin mul_x = rem_q; mul_y = sb_q; end
      2'd2:    begin mul_x = sa_q;  mul_y = ta;   end
      default: begin mul_x = sb_q;  mul_y = tb;   end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    bit_d       = bit_q;
    sub_d       = sub_q;
    size_d      = size_q;
    acc_d       = acc_q;
    os_d        = os_q;
    incomp_d    = incomp_q;
    ovf_d       = ovf_q;
    lin_d       = lin_q;
    rem_d       = rem_q;
    sa_d        = sa_q;
    sb_d        = sb_q;
    offa_d      = offa_q;
    offb_d      = offb_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctl         = '0;
    ctl.load_pos = in_data_i.dim_position;
    ctl.load_ext = in_data_i.extent;
    head_one    = 1'b0;
    in_ready_o  = 1'b0;

    case (state_q)
      bof_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d = in_data_i;
          res_d  = '0;
          state_d = bof_pkg::S_DONE;
          case (bof_pkg::bof_op_e'(in_data_i.opcode))
            bof_pkg::OP_LOAD_A, bof_pkg::OP_LOAD_B: begin
              if (in_data_i.extent == 32'd0) begin
                res_d.status = bof_pkg::ST_ZERO_EXTENT;
              end else begin
                ctl.load_a = (in_data_i.opcode == bof_pkg::OP_LOAD_A);
                ctl.load_b = (in_data_i.opcode == bof_pkg::OP_LOAD_B);
              end
            end
            bof_pkg::OP_MAP: begin
              ctl.copy = 1'b1;
              k_d      = '0;
              state_d  = bof_pkg::S_ALIGN;
            end
            default: ;
          endcase
        end
      end

      // Shift each operand toward the tail until its last dimension sits there.
      bof_pkg::S_ALIGN: begin
        head_one    = 1'b1;
        ctl.shift_a = (k_q < sh_a);
        ctl.shift_b = (k_q < sh_b);
        k_d         = k_q + KW'(1);
        if (k_q == KW'(MAX_DIMS - 1)) begin
          k_d      = '0;
          size_d   = IB'(1);
          incomp_d = 1'b0;
          ovf_d    = 1'b0;
          state_d  = bof_pkg::S_SZ_CHK;
        end
      end

      bof_pkg::S_SZ_CHK: begin
        if (ta != tb && ta != 32'd1 && tb != 32'd1) begin
          incomp_d = 1'b1;
        end
        os_d    = os_max;
        acc_d   = '0;
        bit_d   = 5'd31;
        state_d = (ovf_q || incomp_q) ? bof_pkg::S_SZ_NEXT : bof_pkg::S_SZ_MUL;
      end

      // Shift-add multiply of the running size by one output extent, most
      // significant bit first; the partial product only grows, so the limit
      // check may stop it early.
      bof_pkg::S_SZ_MUL: begin
        acc_d = acc_n;
        bit_d = bit_q - 5'd1;
        if (acc_n[IB+1:IB] != 2'd0) begin
          ovf_d   = 1'b1;
          state_d = bof_pkg::S_SZ_NEXT;
        end else if (bit_q == 5'd0) begin
          size_d  = acc_n[IB-1:0];
          state_d = bof_pkg::S_SZ_NEXT;
        end
      end

      bof_pkg::S_SZ_NEXT: begin
        ctl.shift_a = 1'b1;
        ctl.shift_b = 1'b1;
        k_d         = k_q + KW'(1);
        state_d     = bof_pkg::S_SZ_CHK;
        if (k_q == KW'(MAX_DIMS - 1)) begin
          k_d     = '0;
          state_d = bof_pkg::S_SZ_END;
        end
      end

      bof_pkg::S_SZ_END: begin
        res_d   = '0;
        state_d = bof_pkg::S_DONE;
        if (incomp_q) begin
          res_d.status = bof_pkg::ST_NOT_BROADCASTABLE;
        end else if (ovf_q) begin
          res_d.output_size = lim_cw[31:0];
          res_d.status      = bof_pkg::ST_SIZE_OVERFLOW;
        end else begin
          res_d.output_size = size_cw[31:0];
          if (CW'(item_q.linear_index) >= size_cw) begin
            res_d.status = bof_pkg::ST_INDEX_TOO_LARGE;
          end else begin
            lin_d   = item_q.linear_index;
            sa_d    = 32'd1;
            sb_d    = 32'd1;
            offa_d  = '0;
            offb_d  = '0;
            state_d = bof_pkg::S_DV_CHK;
          end
        end
      end

      bof_pkg::S_DV_CHK: begin
        os_d    = os_max;
        rem_d   = '0;
        bit_d   = 5'd31;
        state_d = bof_pkg::S_DV;
      end

      // Restoring division: the remainder is the coordinate in this dimension
      // and the quotient carries on to the next one.
      bof_pkg::S_DV: begin
        rem_d = div_ge ? 32'(div_r - {1'b0, os_q}) : div_r[31:0];
        lin_d = {lin_q[30:0], div_ge};
        bit_d = bit_q - 5'd1;
        if (bit_q == 5'd0) begin
          sub_d   = 2'd0;
          state_d = bof_pkg::S_MUL;
        end
      end

      // Four steps on the shared multiplier: both offsets, then both strides.
      bof_pkg::S_MUL: begin
        sub_d = sub_q + 2'd1;
        case (sub_q)
          2'd0: if (ta != 32'd1) offa_d = offa_q + mul_p[31:0];
          2'd1: if (tb != 32'd1) offb_d = offb_q + mul_p[31:0];
          2'd2: sa_d = mul_p[31:0];
          default: begin
            sb_d        = mul_p[31:0];
            ctl.shift_a = 1'b1;
            ctl.shift_b = 1'b1;
            k_d         = k_q + KW'(1);
            state_d     = bof_pkg::S_DV_CHK;
            if (k_q == KW'(MAX_DIMS - 1)) begin
              res_d.a_offset = offa_q;
              res_d.b_offset = offb_q;
              state_d        = bof_pkg::S_DONE;
            end
          end
        endcase
      end

      bof_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = bof_pkg::S_IDLE;
        end
      end

      default: state_d = bof_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bof_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      bit_q       <= '0;
      sub_q       <= '0;
      incomp_q    <= 1'b0;
      ovf_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      bit_q       <= bit_d;
      sub_q       <= sub_d;
      incomp_q    <= incomp_d;
      ovf_q       <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    acc_q  <= acc_d;
    os_q   <= os_d;
    lin_q  <= lin_d;
    rem_q  <= rem_d;
    sa_q   <= sa_d;
    sb_q   <= sb_d;
    offa_q <= offa_d;
    offb_q <= offb_d;
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == bof_pkg::S_IDLE)
    else $error("input taken while an item is in progress");

  a_fail_zero_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != bof_pkg::ST_OK
      |-> out_data_o.a_offset == 32'd0 && out_data_o.b_offset == 32'd0)
    else $error("nonzero offset on a failed item");

  a_ovf_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == bof_pkg::ST_SIZE_OVERFLOW
      |-> out_data_o.output_size == lim_cw[31:0])
    else $error("overflowed size not saturated");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == bof_pkg::S_DONE)
    else $error("result presented without a finished item");
`endif

endmodule

### tb/bof_checker.sv
// Scoreboard for the broadcast offset generator: watches the input, output and APB ports.
// Predicts every result from its own copy of the extents and ranks. Depends on bof_pkg.
module bof_checker #(
  parameter int unsigned DIMS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  bof_pkg::bof_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  bof_pkg::bof_out_t out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [2:0]        paddr_i,
  input  logic [31:0]       pwdata_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SIZE_LIMIT = 64'hFFFF_FFFF;

  logic [31:0]       first_ext  [DIMS];
  logic [31:0]       second_ext [DIMS];
  logic [3:0]        first_rank;
  logic [3:0]        second_rank;
  bof_pkg::bof_out_t expected_q [$];

  function automatic int unsigned clamp_rank(logic [3:0] r);
    if (r == 0) return 1;
    if (r > DIMS) return DIMS;
    return r;
  endfunction

  // Offset of one operand for a linear output index, walking from the last dimension.
  function automatic longint unsigned operand_offset(logic [31:0] ext [DIMS], int unsigned rank,
                                                     longint unsigned oshape [DIMS],
                                                     int unsigned nd, longint unsigned lin);
    longint unsigned offs, stride, coord;
    int unsigned shift;
    offs = 0;
    stride = 1;
    shift = nd - rank;
    for (int d = nd - 1; d >= 0; d--) begin
      coord = lin % oshape[d];
      lin = lin / oshape[d];
      if (d >= shift) begin
        if (ext[d - shift] != 1) offs += coord * stride;
        stride *= ext[d - shift];
      end
    end
    return offs;
  endfunction

  // Applies one input item to the model state and returns the result it causes.
  function automatic bof_pkg::bof_out_t apply_item(bof_pkg::bof_in_t it);
    bof_pkg::bof_out_t r;
    int unsigned ar, br, nd;
    longint unsigned oshape [DIMS];
    longint unsigned ad, bd, size;
    logic overflow;
    r = '0;
    r.status = bof_pkg::ST_OK;
    case (bof_pkg::bof_op_e'(it.opcode))
      bof_pkg::OP_LOAD_A, bof_pkg::OP_LOAD_B: begin
        if (it.extent == 0) r.status = bof_pkg::ST_ZERO_EXTENT;
        else if (it.dim_position < DIMS) begin
          if (it.opcode == bof_pkg::OP_LOAD_A) first_ext[it.dim_position] = it.extent;
          else second_ext[it.dim_position] = it.extent;
        end
      end
      bof_pkg::OP_MAP: begin
        ar = clamp_rank(first_rank);
        br = clamp_rank(second_rank);
        nd = (ar > br) ? ar : br;
        for (int i = 0; i < nd; i++) begin
          ad = (i < nd - ar) ? 1 : first_ext[i - (nd - ar)];
          bd = (i < nd - br) ? 1 : second_ext[i - (nd - br)];
          if (ad != bd && ad != 1 && bd != 1) begin
            r.status = bof_pkg::ST_NOT_BROADCASTABLE;
            return r;
          end
          oshape[i] = (ad > bd) ? ad : bd;
        end
        size = 1;
        overflow = 1'b0;
        for (int i = 0; i < nd; i++) begin
          if (!overflow) begin
            if (size > SIZE_LIMIT / oshape[i]) overflow = 1'b1;
            else size *= oshape[i];
          end
        end
        if (overflow) begin
          r.output_size = SIZE_LIMIT[31:0];
          r.status = bof_pkg::ST_SIZE_OVERFLOW;
          return r;
        end
        r.output_size = size[31:0];
        if (it.linear_index >= size) begin
          r.status = bof_pkg::ST_INDEX_TOO_LARGE;
          return r;
        end
        r.a_offset = 32'(operand_offset(first_ext, ar, oshape, nd, it.linear_index));
        r.b_offset = 32'(operand_offset(second_ext, br, oshape, nd, it.linear_index));
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bof_pkg::bof_out_t want;
    int bad;
    if (!rst_ni) begin
      for (int i = 0; i < DIMS; i++) begin
        first_ext[i] = 32'd1;
        second_ext[i] = 32'd1;
      end
      first_rank = 4'd1;
      second_rank = 4'd1;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      bad = 0;
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == bof_pkg::REG_B_RANK) second_rank = pwdata_i[3:0];
        else first_rank = pwdata_i[3:0];
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(apply_item(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          bad++;
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.a_offset !== want.a_offset) begin
            $error("a_offset expected %0d got %0d", want.a_offset, out_data_i.a_offset);
            bad++;
          end
          if (out_data_i.b_offset !== want.b_offset) begin
            $error("b_offset expected %0d got %0d", want.b_offset, out_data_i.b_offset);
            bad++;
          end
          if (out_data_i.output_size !== want.output_size) begin
            $error("output_size expected %0d got %0d", want.output_size,
                   out_data_i.output_size);
            bad++;
          end
          if (out_data_i.status !== want.status) begin
            $error("status expected %0d got %0d", want.status, out_data_i.status);
            bad++;
          end
        end
        checked_o <= checked_o + 1;
      end
      if (bad != 0) fail_count_o <= fail_count_o + 1;
      pending_o <= expected_q.size();
    end
  end

endmodule

### tb/tb_broadcast_offset_generator_top.sv
// Stimulus and verdict for the broadcast offset generator.
// Depends on bof_pkg, broadcast_offset_generator_top and bof_checker.
module tb_broadcast_offset_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DIMS        = 8;
  localparam int          ITEM_TARGET = 1450;
  // Allow for full eight-dimension maps and for stalls, and take margin.
  localparam longint      CYCLE_LIMIT = 6_000_000;
  localparam int          TAIL_CYCLES = 800;
  localparam int          HOLD_CYCLES = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  bof_pkg::bof_in_t  in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  bof_pkg::bof_out_t out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int     fail_count, pending, checked;
  int     items_sent = 0;
  int     sender_idle_pct = 0;
  int     receiver_idle_pct = 0;
  logic   hold_request = 1'b0;
  longint cycle = 0;

  always #10 clk_i = ~clk_i;

  broadcast_offset_generator_top #(.MAX_DIMS(DIMS), .INDEX_BITS(32)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  bof_checker #(.DIMS(DIMS)) u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side. Ready is rolled every cycle against the current idle share, except
  // during a requested hold-off, which this process times itself so that the block
  // backs up and stops taking input while the sender keeps offering transfers.
  always @(posedge clk_i) begin
    int hold_left;
    bit hold_taken;
    if (hold_request && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Offers one input transfer and returns once it has been taken. Valid is only
  // lowered when an idle gap is actually inserted, so back-to-back transfers keep
  // it high without a second assignment in the same step.
  task automatic send_item(bof_pkg::bof_op_e op, logic [2:0] pos, logic [31:0] ext,
                           logic [31:0] idx);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{opcode: op, dim_position: pos, extent: ext, linear_index: idx};
    @(posedge clk_i iff in_ready_o);
    items_sent++;
  endtask

  // Waits until every expected result has come back; the block is then idle, as
  // every item yields exactly one result.
  task automatic drain();
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // One write with its setup and access phases, after which the bus returns to idle.
  task automatic apb_write(logic reg_sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i iff pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Rank write with junk in the unused upper bits. A rank of 1 is sometimes
  // written as 0 and a rank of 8 sometimes as 9 to 15, which the block clamps.
  function automatic logic [31:0] rank_word(int unsigned rank);
    logic [3:0] code;
    code = 4'(rank);
    if (rank == 1 && $urandom_range(3) == 0) code = 4'd0;
    if (rank == DIMS && $urandom_range(1) == 0) code = 4'($urandom_range(9, 15));
    return {$urandom() & 32'hFFFF_FFF0} | 32'(code);
  endfunction

  task automatic set_ranks(int unsigned ar, int unsigned br);
    drain();
    apb_write(bof_pkg::REG_A_RANK, rank_word(ar));
    apb_write(bof_pkg::REG_B_RANK, rank_word(br));
  endtask

  // Mostly shallow shapes keep maps short; the full depth still turns up.
  function automatic int unsigned pick_rank();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(1, 2);
    if (r < 85) return $urandom_range(3, 4);
    if (r < 95) return $urandom_range(5, 7);
    return DIMS;
  endfunction

  task automatic send_noise();
    send_item(bof_pkg::bof_op_e'($urandom_range(3)), 3'($urandom), $urandom(), $urandom());
  endtask

  // One well-formed scenario: pick ranks, build an output shape, load both operands
  // with extents that mostly match it or are 1, then map a handful of indices.
  task automatic run_shape();
    int unsigned ar, br, nd, nmaps;
    logic [31:0] oshape [DIMS];
    logic [31:0] ext;
    longint unsigned size;
    logic [31:0] idx;
    ar = pick_rank();
    br = pick_rank();
    nd = (ar > br) ? ar : br;
    if ($urandom_range(4) == 0) set_ranks(ar, br);
    else begin
      // Otherwise both ranks are set to the output rank, which also forces a drain.
      ar = 0;
    end
    if (ar == 0) begin
      ar = nd;
      br = nd;
      set_ranks(ar, br);
    end
    size = 1;
    for (int i = 0; i < nd; i++) begin
      oshape[i] = ($urandom_range(29) == 0) ? $urandom() | 32'd1 : $urandom_range(1, 4);
      size = (size > 64'hFFFF_FFFF) ? size : size * oshape[i];
    end
    for (int i = 0; i < ar; i++) begin
      ext = ($urandom_range(2) == 0) ? 32'd1 : oshape[nd - ar + i];
      if ($urandom_range(15) == 0) ext = $urandom_range(0, 6);
      send_item(bof_pkg::OP_LOAD_A, 3'(i), ext, $urandom());
    end
    for (int i = 0; i < br; i++) begin
      ext = ($urandom_range(2) == 0) ? 32'd1 : oshape[nd - br + i];
      if ($urandom_range(15) == 0) ext = $urandom_range(0, 6);
      send_item(bof_pkg::OP_LOAD_B, 3'(i), ext, $urandom());
    end
    nmaps = $urandom_range(4, 10);
    repeat (nmaps) begin
      if (size > 64'hFFFF_FFFF || $urandom_range(9) == 0) idx = $urandom();
      else if ($urandom_range(7) == 0) idx = 32'(size) + $urandom_range(0, 3);
      else idx = $urandom_range(0, 32'(size - 1));
      send_item(bof_pkg::OP_MAP, 3'($urandom), $urandom(), idx);
    end
  endtask

  initial begin
    int target;
    int unsigned sender_pct [3];
    int unsigned receiver_pct [3];
    sender_pct = '{23, 72, 0};
    receiver_pct = '{72, 23, 0};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sender_idle_pct = sender_pct[0];
    receiver_idle_pct = receiver_pct[0];

    // Directed part, starting from the reset shape of rank one with extent 1.
    send_item(bof_pkg::OP_MAP, 3'd0, 32'd0, 32'd0);
    send_item(bof_pkg::OP_MAP, 3'd0, 32'd0, 32'd1);
    send_item(bof_pkg::OP_MAP, 3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bof_pkg::OP_LOAD_A, 3'd0, 32'd0, 32'd0);
    send_item(bof_pkg::OP_LOAD_B, 3'd7, 32'd0, 32'd0);
    send_item(bof_pkg::OP_NONE, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bof_pkg::OP_LOAD_B, 3'd7, 32'd9, 32'd0);
    set_ranks(3, 2);
    send_item(bof_pkg::OP_LOAD_A, 3'd0, 32'd2, 32'd0);
    send_item(bof_pkg::OP_LOAD_A, 3'd1, 32'd3, 32'd0);
    send_item(bof_pkg::OP_LOAD_A, 3'd2, 32'd4, 32'd0);
    send_item(bof_pkg::OP_LOAD_B, 3'd0, 32'd3, 32'd0);
    send_item(bof_pkg::OP_LOAD_B, 3'd1, 32'd1, 32'd0);
    send_item(bof_pkg::OP_MAP, 3'd0, 32'd0, 32'd23);
    send_item(bof_pkg::OP_MAP, 3'd0, 32'd0, 32'd24);
    send_item(bof_pkg::OP_MAP, 3'd0, 32'd0, 32'd13);
    // Mismatched middle dimension, then restored, then a saturating leading one.
    send_item(bof_pkg::OP_LOAD_B, 3'd0, 32'd5, 32'd0);
    send_item(bof_pkg::OP_MAP, 3'd0, 32'd0, 32'd0);
    send_item(bof_pkg::OP_LOAD_B, 3'd0, 32'd3, 32'd0);
    send_item(bof_pkg::OP_LOAD_A, 3'd0, 32'hFFFF_FFFF, 32'd0);
    send_item(bof_pkg::OP_MAP, 3'd0, 32'd0, 32'd5);

    // Long receiver hold-off while loads keep coming, so the input backs up.
    hold_request <= 1'b1;
    repeat (8) begin
      send_item(bof_pkg::OP_LOAD_B, 3'($urandom_range(2, 7)), $urandom_range(1, 9),
                $urandom());
    end

    // Random part in three flow-control settings.
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      sender_idle_pct = sender_pct[phase];
      receiver_idle_pct = receiver_pct[phase];
      target = ITEM_TARGET * (phase + 1) / 3;
      while (items_sent < target) begin
        if ($urandom_range(9) < 8) run_shape();
        else repeat (6) send_noise();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d input transfers and checked %0d results", items_sent, checked);
    $display("under three idling mixes, a long output hold-off and ranks from 0 to 15.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
